@@ hdl/ers_pkg.sv @@
// ers_pkg: shared types and constants for the elevator request scheduler.
// Used by ers_cell and elevator_request_scheduler; no dependencies.
package ers_pkg;

  localparam int FLOORS_DEF = 4;   // default floor count
  localparam int KINDS      = 3;   // hall up, cab, hall down
  localparam int MAX_BFL    = 4;   // floors that own request bits (12-bit fields)
  localparam int FLOOR_W    = 2;
  localparam int MASK_W     = 12;
  localparam int CNT_W      = 4;

  typedef enum logic [1:0] {
    ACT_LATCH = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_FLUSH = 2'd2,
    ACT_QUERY = 2'd3
  } act_t;

  localparam logic [1:0] DIR_UP   = 2'd0;
  localparam logic [1:0] DIR_DOWN = 2'd1;

  // Broadcast command to every cell on an accepted beat.
  typedef struct packed {
    logic               upd;
    act_t               act;
    logic [FLOOR_W-1:0] floor;
  } cell_ctl_t;

  // Nearest-hit record passed along the chain.
  // hs/fs: hit on a same-direction kind, ha/fa: hit on any kind.
  typedef struct packed {
    logic               hs;
    logic [FLOOR_W-1:0] fs;
    logic               ha;
    logic [FLOOR_W-1:0] fa;
  } rec_t;

endpackage

@@ hdl/ers_cell.sv @@
// ers_cell: one floor of the request chain; holds the floor's three request bits
// and registers the nearest-hit records and the running request count. Uses ers_pkg.
module ers_cell #(
  parameter int IDX = 0
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ers_pkg::cell_ctl_t         ctl,
  input  logic [ers_pkg::KINDS-1:0]  btn,
  input  ers_pkg::rec_t              abv_in,   // from the floor above
  input  ers_pkg::rec_t              blw_in,   // from the floor below
  input  logic [ers_pkg::CNT_W-1:0]  cnt_in,   // from the floor above
  output logic [ers_pkg::KINDS-1:0]  bits,
  output ers_pkg::rec_t              abv_out,  // nearest hit at or above
  output ers_pkg::rec_t              blw_out,  // nearest hit at or below
  output logic [ers_pkg::CNT_W-1:0]  cnt_out   // requests at or above
);

  localparam logic [ers_pkg::FLOOR_W-1:0] ME = ers_pkg::FLOOR_W'(IDX);

  logic [ers_pkg::KINDS-1:0] bits_r, bits_nxt;
  ers_pkg::rec_t             abv_r, abv_nxt, blw_r, blw_nxt;
  logic [ers_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                      any_hit, up_hit, dn_hit;

  always_comb begin
    bits_nxt = bits_r;
    if (ctl.upd) begin
      unique case (ctl.act)
        ers_pkg::ACT_LATCH: bits_nxt = bits_r | btn;
        ers_pkg::ACT_CLEAR: if (ctl.floor == ME) bits_nxt = '0;
        ers_pkg::ACT_FLUSH: bits_nxt = '0;
        ers_pkg::ACT_QUERY: bits_nxt = bits_r;
        default:            bits_nxt = bits_r;
      endcase
    end
  end

  always_comb begin
    any_hit = |bits_r;
    up_hit  = bits_r[0] | bits_r[1];   // hall up or cab
    dn_hit  = bits_r[1] | bits_r[2];   // cab or hall down

    abv_nxt.hs = up_hit | abv_in.hs;
    abv_nxt.fs = up_hit ? ME : abv_in.fs;
    abv_nxt.ha = any_hit | abv_in.ha;
    abv_nxt.fa = any_hit ? ME : abv_in.fa;

    blw_nxt.hs = dn_hit | blw_in.hs;
    blw_nxt.fs = dn_hit ? ME : blw_in.fs;
    blw_nxt.ha = any_hit | blw_in.ha;
    blw_nxt.fa = any_hit ? ME : blw_in.fa;

    cnt_nxt = cnt_in + ers_pkg::CNT_W'(bits_r[0]) + ers_pkg::CNT_W'(bits_r[1])
            + ers_pkg::CNT_W'(bits_r[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r <= '0;
      abv_r  <= '0;
      blw_r  <= '0;
      cnt_r  <= '0;
    end else begin
      bits_r <= bits_nxt;
      abv_r  <= abv_nxt;
      blw_r  <= blw_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  assign bits    = bits_r;
  assign abv_out = abv_r;
  assign blw_out = blw_r;
  assign cnt_out = cnt_r;

endmodule

@@ hdl/elevator_request_scheduler.sv @@
// elevator_request_scheduler: top level; a chain of ers_cell floors plus the
// sequencer that applies the action, waits for the chain to settle and sweeps.
// Depends on ers_pkg and ers_cell.
//
// The result strobe is registered once the sequencer has counted out the settle
//   steps; BFL = min(FLOORS, 4) is the length of the cell chain.
// A beat is taken only while idle; busy drops in the strobe cycle, so the
//   next beat can be taken while the result is shown. The settle time is the
//   ripple of the registered hit records and count down the cell chain.
// Reset (rst_n low, synchronous): all request bits and the count clear, idle.
// The result strobe cannot be held off by the receiver.
module elevator_request_scheduler #(
  parameter int FLOORS = ers_pkg::FLOORS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_action,
  input  logic [ers_pkg::MASK_W-1:0]   in_button_mask,
  input  logic [ers_pkg::FLOOR_W-1:0]  in_floor,
  input  logic [1:0]                   in_direction,
  output logic                         out_valid,
  output logic [ers_pkg::FLOOR_W-1:0]  out_next_floor,
  output logic                         out_next_valid,
  output logic [ers_pkg::MASK_W-1:0]   out_lamp_mask,
  output logic [ers_pkg::CNT_W-1:0]    out_active_count
);

  // Floors that actually own request bits; the rest never hold requests.
  localparam int BFL   = (FLOORS < ers_pkg::MAX_BFL) ? FLOORS : ers_pkg::MAX_BFL;
  localparam int SCW   = $clog2(BFL + 1);
  localparam int IW    = $clog2(BFL);
  localparam int LAMPB = ers_pkg::KINDS * BFL;
  localparam logic [4:0]     TOP_FL = 5'(FLOORS - 1);
  localparam logic [SCW-1:0] SETTLE = SCW'(BFL);

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_t;

  state_t                        state_r;
  logic [SCW-1:0]                step_r;
  logic [ers_pkg::FLOOR_W-1:0]   cur_r;
  logic [1:0]                    dir_r;
  logic                          out_valid_r;
  logic [ers_pkg::FLOOR_W-1:0]   next_floor_r;
  logic                          next_valid_r;
  logic [ers_pkg::MASK_W-1:0]    lamp_r;
  logic [ers_pkg::CNT_W-1:0]     count_r;

  logic                          accept;
  ers_pkg::cell_ctl_t            ctl;
  logic [ers_pkg::FLOOR_W-1:0]   cur_sat;

  logic [ers_pkg::KINDS-1:0]     bits_q [BFL];
  ers_pkg::rec_t                 abv_q  [BFL];
  ers_pkg::rec_t                 blw_q  [BFL];
  logic [ers_pkg::CNT_W-1:0]     cnt_q  [BFL];
  logic [ers_pkg::MASK_W-1:0]    lamp_w;

  ers_pkg::rec_t                 rec_up, rec_dn;
  logic [2:0]                    up_idx;
  logic [1:0]                    eff_dir;
  logic                          tgt_ok;
  logic [ers_pkg::FLOOR_W-1:0]   tgt_fl;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  // Search floor: anything past the top saturates to the top floor.
  assign cur_sat = ({3'b000, in_floor} > TOP_FL) ? ers_pkg::FLOOR_W'(TOP_FL) : in_floor;

  always_comb begin
    ctl.upd   = accept;
    ctl.act   = ers_pkg::act_t'(in_action);
    ctl.floor = in_floor;
  end

  // ---------------------------------------------------------------------------
  // Cell chain: hit records above ripple downward, records below ripple
  // upward, the request count accumulates from the top floor down to cell 0.
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < BFL; i++) begin : g_cell
    ers_pkg::rec_t             abv_src, blw_src;
    logic [ers_pkg::CNT_W-1:0] cnt_src;

    if (i == BFL - 1) begin : g_top
      assign abv_src = '0;
      assign cnt_src = '0;
    end else begin : g_mid
      assign abv_src = abv_q[i+1];
      assign cnt_src = cnt_q[i+1];
    end

    if (i == 0) begin : g_bot
      assign blw_src = '0;
    end else begin : g_up
      assign blw_src = blw_q[i-1];
    end

    ers_cell #(
      .IDX (i)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .btn     (in_button_mask[ers_pkg::KINDS*i +: ers_pkg::KINDS]),
      .abv_in  (abv_src),
      .blw_in  (blw_src),
      .cnt_in  (cnt_src),
      .bits    (bits_q[i]),
      .abv_out (abv_q[i]),
      .blw_out (blw_q[i]),
      .cnt_out (cnt_q[i])
    );

    assign lamp_w[ers_pkg::KINDS*i +: ers_pkg::KINDS] = bits_q[i];
  end

  if (LAMPB < ers_pkg::MASK_W) begin : g_lamp_pad
    assign lamp_w[ers_pkg::MASK_W-1:LAMPB] = '0;
  end

  // ---------------------------------------------------------------------------
  // Sweep on settled chain data. Nearest above the current floor is the record
  // of the cell one up; nearest below is the record of the cell one down.
  // ---------------------------------------------------------------------------
  always_comb begin
    up_idx = {1'b0, cur_r} + 3'd1;
    rec_up = '0;
    rec_dn = '0;
    if (up_idx < 3'(BFL)) rec_up = abv_q[up_idx[IW-1:0]];
    if (cur_r != '0)      rec_dn = blw_q[IW'(cur_r - 2'd1)];

    // End floors force the direction.
    if ({3'b000, cur_r} == TOP_FL) eff_dir = ers_pkg::DIR_DOWN;
    else if (cur_r == '0)          eff_dir = ers_pkg::DIR_UP;
    else                           eff_dir = dir_r;

    tgt_ok = 1'b0;
    tgt_fl = '0;
    priority if (cnt_q[0] == '0) begin
      tgt_ok = 1'b0;
    end else if (cnt_q[0] == ers_pkg::CNT_W'(1)) begin
      // single request: its own floor, even the current one
      tgt_ok = abv_q[0].ha;
      tgt_fl = abv_q[0].fa;
    end else if (eff_dir == ers_pkg::DIR_UP) begin
      priority if (rec_up.hs) begin
        tgt_ok = 1'b1; tgt_fl = rec_up.fs;
      end else if (rec_up.ha) begin
        tgt_ok = 1'b1; tgt_fl = rec_up.fa;
      end else if (rec_dn.ha) begin
        tgt_ok = 1'b1; tgt_fl = rec_dn.fa;
      end else begin
        tgt_ok = 1'b0;
      end
    end else if (eff_dir == ers_pkg::DIR_DOWN) begin
      priority if (rec_dn.hs) begin
        tgt_ok = 1'b1; tgt_fl = rec_dn.fs;
      end else if (rec_dn.ha) begin
        tgt_ok = 1'b1; tgt_fl = rec_dn.fa;
      end else if (rec_up.ha) begin
        tgt_ok = 1'b1; tgt_fl = rec_up.fa;
      end else begin
        tgt_ok = 1'b0;
      end
    end else begin
      // stopped at a middle floor: nothing
      tgt_ok = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer and result registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= S_RUN;
            step_r  <= '0;
            cur_r   <= cur_sat;
            dir_r   <= in_direction;
          end
        end
        S_RUN: begin
          if (step_r == SETTLE) begin
            state_r      <= S_IDLE;
            out_valid_r  <= 1'b1;
            next_valid_r <= tgt_ok;
            next_floor_r <= tgt_ok ? tgt_fl : '0;
            lamp_r       <= lamp_w;
            count_r      <= cnt_q[0];
          end else begin
            step_r <= step_r + SCW'(1);
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_next_floor   = next_floor_r;
  assign out_next_valid   = next_valid_r;
  assign out_lamp_mask    = lamp_r;
  assign out_active_count = count_r;

`ifndef ASSERT_OFF
  a_count_matches_lamps: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_active_count == ers_pkg::CNT_W'($countones(out_lamp_mask))))
    else $error("active count disagrees with lamp mask");

  a_no_target_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_next_valid |-> (out_next_floor == '0))
    else $error("next floor nonzero without a target");

  a_target_needs_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_next_valid |-> (out_active_count != '0))
    else $error("target reported with no active request");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy && !out_valid)
    else $error("accepted beat did not start the sweep");
`endif

endmodule

@@ tb/tb_elevator_request_scheduler.sv @@
// Self-checking testbench for elevator_request_scheduler: directed and random
// request traffic, every result checked against an in-bench LOOK sweep model.
// Depends on ers_pkg and the elevator_request_scheduler RTL.
`timescale 1ns / 1ps

module tb_elevator_request_scheduler;

  localparam int N_FLOORS   = ers_pkg::FLOORS_DEF;
  localparam int BIT_FLOORS = (N_FLOORS < ers_pkg::MAX_BFL) ? N_FLOORS : ers_pkg::MAX_BFL;

  // Direction codes the package does not name; code 3 behaves as stopped.
  localparam logic [1:0] DIR_STOP     = 2'd2;
  localparam logic [1:0] DIR_STOP_ALT = 2'd3;

  // Request kinds within a floor's 3-bit group.
  localparam int KIND_UP   = 0;
  localparam int KIND_CAB  = 1;
  localparam int KIND_DOWN = 2;

  // Kinds that match the travel direction in the first pass of the sweep.
  localparam logic [ers_pkg::KINDS-1:0] UP_KINDS   = 3'b011;
  localparam logic [ers_pkg::KINDS-1:0] DOWN_KINDS = 3'b110;

  typedef struct packed {
    logic [ers_pkg::FLOOR_W-1:0] next_floor;
    logic                        next_valid;
    logic [ers_pkg::MASK_W-1:0]  lamp;
    logic [ers_pkg::CNT_W-1:0]   count;
  } sched_result_t;

  logic                         clk;
  logic                         rst_n;
  logic                         start;
  logic                         busy;
  logic [1:0]                   in_action;
  logic [ers_pkg::MASK_W-1:0]   in_button_mask;
  logic [ers_pkg::FLOOR_W-1:0]  in_floor;
  logic [1:0]                   in_direction;
  logic                         out_valid;
  logic [ers_pkg::FLOOR_W-1:0]  out_next_floor;
  logic                         out_next_valid;
  logic [ers_pkg::MASK_W-1:0]   out_lamp_mask;
  logic [ers_pkg::CNT_W-1:0]    out_active_count;

  // Model copy of the request bits; the count is always their popcount.
  logic [ers_pkg::MASK_W-1:0] req_bits;

  sched_result_t pending_sched_q[$];
  int            beats_taken;
  int            err_count;

  elevator_request_scheduler dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_action        (in_action),
    .in_button_mask   (in_button_mask),
    .in_floor         (in_floor),
    .in_direction     (in_direction),
    .out_valid        (out_valid),
    .out_next_floor   (out_next_floor),
    .out_next_valid   (out_next_valid),
    .out_lamp_mask    (out_lamp_mask),
    .out_active_count (out_active_count)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // ---------------------------------------------------------------------
  // Sweep model
  // ---------------------------------------------------------------------

  function automatic logic [ers_pkg::KINDS-1:0] floor_req(logic [ers_pkg::MASK_W-1:0] bits,
                                                          int f);
    if (f < 0 || f >= BIT_FLOORS) return '0;
    return bits[f*ers_pkg::KINDS +: ers_pkg::KINDS];
  endfunction

  function automatic logic [ers_pkg::MASK_W-1:0] req_bit(int f, int kind);
    logic [ers_pkg::MASK_W-1:0] m;
    m = '0;
    m[f*ers_pkg::KINDS + kind] = 1'b1;
    return m;
  endfunction

  // Target floor of the sweep, or -1 when there is none.
  function automatic int pick_target(logic [ers_pkg::MASK_W-1:0] bits, logic [1:0] cur_fl,
                                     logic [1:0] dir);
    int         c;
    int         f;
    logic [1:0] d;
    c = int'(cur_fl);
    d = dir;
    if (bits == '0) return -1;
    // A lone request is served wherever it is, own floor included.
    if ($countones(bits) == 1) begin
      for (f = 0; f < BIT_FLOORS; f++)
        if (floor_req(bits, f) != '0) return f;
      return -1;
    end
    // End floors force the direction; a middle floor keeps it.
    if (c >= N_FLOORS - 1) begin
      d = ers_pkg::DIR_DOWN;
    end else if (c == 0) begin
      d = ers_pkg::DIR_UP;
    end
    if (d == ers_pkg::DIR_UP) begin
      for (f = c + 1; f < BIT_FLOORS; f++)
        if ((floor_req(bits, f) & UP_KINDS) != '0) return f;
      for (f = c + 1; f < BIT_FLOORS; f++)
        if (floor_req(bits, f) != '0) return f;
      for (f = c - 1; f >= 0; f--)
        if (floor_req(bits, f) != '0) return f;
    end else if (d == ers_pkg::DIR_DOWN) begin
      for (f = c - 1; f >= 0; f--)
        if ((floor_req(bits, f) & DOWN_KINDS) != '0) return f;
      for (f = c - 1; f >= 0; f--)
        if (floor_req(bits, f) != '0) return f;
      for (f = c + 1; f < BIT_FLOORS; f++)
        if (floor_req(bits, f) != '0) return f;
    end
    // Stopped between the end floors: nothing found.
    return -1;
  endfunction

  // Applies one command to the model bits and returns the expected beat.
  function automatic sched_result_t schedule_step(ers_pkg::act_t act,
                                                  logic [ers_pkg::MASK_W-1:0] mask,
                                                  logic [1:0] fl, logic [1:0] dir);
    sched_result_t r;
    int            tgt;
    case (act)
      ers_pkg::ACT_LATCH: req_bits = req_bits | mask;
      ers_pkg::ACT_CLEAR: begin
        if (int'(fl) < BIT_FLOORS)
          req_bits[int'(fl)*ers_pkg::KINDS +: ers_pkg::KINDS] = '0;
      end
      ers_pkg::ACT_FLUSH: req_bits = '0;
      default: ;
    endcase
    tgt          = pick_target(req_bits, fl, dir);
    r.next_valid = (tgt >= 0);
    r.next_floor = (tgt >= 0) ? ers_pkg::FLOOR_W'(tgt) : '0;
    r.lamp       = req_bits;
    r.count      = ers_pkg::CNT_W'($countones(req_bits));
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0t: %s", $time, msg);
    err_count++;
  endtask

  // One process per edge: check the strobed beat against the oldest
  // prediction first, then predict the beat accepted at this edge. A strobe
  // and a new accept may share an edge since busy drops in the strobe cycle.
  always @(posedge clk) begin
    sched_result_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (pending_sched_q.size() == 0) begin
          report_mismatch("result beat with nothing pending");
        end else begin
          want = pending_sched_q.pop_front();
          if (out_next_valid !== want.next_valid)
            report_mismatch($sformatf("next_valid %b, want %b",
                                      out_next_valid, want.next_valid));
          if (out_next_floor !== want.next_floor)
            report_mismatch($sformatf("next_floor %0d, want %0d",
                                      out_next_floor, want.next_floor));
          if (out_lamp_mask !== want.lamp)
            report_mismatch($sformatf("lamp_mask %h, want %h", out_lamp_mask, want.lamp));
          if (out_active_count !== want.count)
            report_mismatch($sformatf("active_count %0d, want %0d",
                                      out_active_count, want.count));
        end
      end
      if (start && !busy) begin
        pending_sched_q.push_back(schedule_step(ers_pkg::act_t'(in_action), in_button_mask,
                                                in_floor, in_direction));
        beats_taken++;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------

  // Called at a falling edge; returns at the falling edge after the accept.
  // start stays high into the next command unless a gap is asked for.
  task automatic send_cmd(input ers_pkg::act_t act, input logic [ers_pkg::MASK_W-1:0] mask,
                          input logic [1:0] fl, input logic [1:0] dir, input int gap);
    int seen;
    seen           = beats_taken;
    start          <= 1'b1;
    in_action      <= act;
    in_button_mask <= mask;
    in_floor       <= fl;
    in_direction   <= dir;
    do @(negedge clk); while (beats_taken == seen);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Mostly back to back or short, now and then a long pause.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 7);
    return $urandom_range(10, 40);
  endfunction

  task automatic test_empty_query;
    send_cmd(ers_pkg::ACT_QUERY, '0, 2'd0, ers_pkg::DIR_UP, 0);
    // Buttons are ignored by a query.
    send_cmd(ers_pkg::ACT_QUERY, '1, 2'd3, DIR_STOP_ALT, 1);
  endtask

  task automatic test_lone_request;
    // Lone request at the current floor is still the target.
    send_cmd(ers_pkg::ACT_LATCH, req_bit(2, KIND_CAB), 2'd2, ers_pkg::DIR_UP, 0);
    send_cmd(ers_pkg::ACT_QUERY, '0, 2'd0, ers_pkg::DIR_DOWN, 2);
    // Already set: not counted twice; stopped mid-shaft still finds it.
    send_cmd(ers_pkg::ACT_LATCH, req_bit(2, KIND_CAB), 2'd1, DIR_STOP, 0);
  endtask

  task automatic test_sweep_order;
    send_cmd(ers_pkg::ACT_FLUSH, '1, 2'd1, ers_pkg::DIR_UP, 0);
    // Only a hall-down above: found by the any-kind pass going up.
    send_cmd(ers_pkg::ACT_LATCH, req_bit(3, KIND_DOWN) | req_bit(0, KIND_UP), 2'd1,
             ers_pkg::DIR_UP, 0);
    // Hall-up below going down: any-kind pass below.
    send_cmd(ers_pkg::ACT_QUERY, '0, 2'd2, ers_pkg::DIR_DOWN, 1);
    // Nearer hall-up above wins over the farther hall-down.
    send_cmd(ers_pkg::ACT_LATCH, req_bit(2, KIND_UP), 2'd1, ers_pkg::DIR_UP, 0);
    send_cmd(ers_pkg::ACT_QUERY, '0, 2'd2, ers_pkg::DIR_DOWN, 3);
  endtask

  task automatic test_end_floors;
    send_cmd(ers_pkg::ACT_LATCH, '1, 2'd0, DIR_STOP, 0);
    send_cmd(ers_pkg::ACT_QUERY, '0, 2'd3, ers_pkg::DIR_UP, 0);
    send_cmd(ers_pkg::ACT_QUERY, '0, 2'd0, ers_pkg::DIR_DOWN, 5);
    send_cmd(ers_pkg::ACT_QUERY, '0, 2'd3, DIR_STOP_ALT, 0);
  endtask

  task automatic test_stopped_middle;
    send_cmd(ers_pkg::ACT_QUERY, '0, 2'd1, DIR_STOP, 0);
    send_cmd(ers_pkg::ACT_QUERY, '0, 2'd2, DIR_STOP_ALT, 1);
  endtask

  task automatic test_clear_and_flush;
    send_cmd(ers_pkg::ACT_CLEAR, '0, 2'd0, ers_pkg::DIR_UP, 0);
    send_cmd(ers_pkg::ACT_CLEAR, '1, 2'd3, ers_pkg::DIR_DOWN, 0);
    send_cmd(ers_pkg::ACT_CLEAR, '0, 2'd1, ers_pkg::DIR_UP, 2);
    send_cmd(ers_pkg::ACT_CLEAR, '0, 2'd1, ers_pkg::DIR_DOWN, 0);   // floor already clear
    send_cmd(ers_pkg::ACT_CLEAR, '0, 2'd2, DIR_STOP, 0);
    send_cmd(ers_pkg::ACT_LATCH, '0, 2'd2, ers_pkg::DIR_UP, 0);     // empty latch
    send_cmd(ers_pkg::ACT_LATCH, 12'h5A5, 2'd1, ers_pkg::DIR_DOWN, 0);
    send_cmd(ers_pkg::ACT_FLUSH, '0, 2'd2, ers_pkg::DIR_UP, 1);
  endtask

  // Mix weighted toward sparse latches, clears and searches so the count
  // moves through zero, one and the crowded cases; flushes restart episodes.
  task automatic test_random_traffic(input int n_items);
    int                         i;
    int                         r;
    int                         gap;
    ers_pkg::act_t              act;
    logic [ers_pkg::MASK_W-1:0] mask;
    logic [1:0]                 dir;
    for (i = 0; i < n_items; i++) begin
      r = $urandom_range(0, 99);
      if (r < 30)      act = ers_pkg::ACT_LATCH;
      else if (r < 55) act = ers_pkg::ACT_CLEAR;
      else if (r < 90) act = ers_pkg::ACT_QUERY;
      else             act = ers_pkg::ACT_FLUSH;
      r = $urandom_range(0, 99);
      if (r < 60) begin
        mask = req_bit($urandom_range(0, BIT_FLOORS - 1),
                       $urandom_range(0, ers_pkg::KINDS - 1));
        if (r < 25)
          mask |= req_bit($urandom_range(0, BIT_FLOORS - 1),
                          $urandom_range(0, ers_pkg::KINDS - 1));
      end else if (r < 90) begin
        mask = ers_pkg::MASK_W'($urandom);
      end else begin
        mask = (r < 95) ? '0 : '1;
      end
      r = $urandom_range(0, 99);
      if (r < 40)      dir = ers_pkg::DIR_UP;
      else if (r < 80) dir = ers_pkg::DIR_DOWN;
      else if (r < 92) dir = DIR_STOP;
      else             dir = DIR_STOP_ALT;
      // A stretch of back-to-back commands in the middle of the run.
      gap = (i >= n_items / 3 && i < n_items / 3 + 150) ? 0 : pick_gap();
      send_cmd(act, mask, ers_pkg::FLOOR_W'($urandom_range(0, 3)), dir, gap);
    end
  endtask

  // Let every pending beat arrive, then watch a while for stray strobes.
  task automatic drain_results;
    int waited;
    start  <= 1'b0;
    waited = 0;
    while (pending_sched_q.size() != 0 && waited < 500) begin
      @(negedge clk);
      waited++;
    end
    while (pending_sched_q.size() != 0) begin
      void'(pending_sched_q.pop_front());
      report_mismatch("expected beat never arrived");
    end
    repeat (12) @(negedge clk);
  endtask

  initial begin
    req_bits       = '0;
    beats_taken    = 0;
    err_count      = 0;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_action      = ers_pkg::ACT_QUERY;
    in_button_mask = '0;
    in_floor       = '0;
    in_direction   = ers_pkg::DIR_UP;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_empty_query();
    test_lone_request();
    test_sweep_order();
    test_end_floors();
    test_stopped_middle();
    test_clear_and_flush();
    test_random_traffic(1200);
    drain_results();

    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Hang guard: far beyond the slowest correct run (every command waiting
  // out the longest gap plus the block's own cycles).
  initial begin
    #1_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
